// ===== design/dfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_pkg: shared types and constants
// Transaction types, working widths and fixed-point constants of the
// dielectric Fresnel reflectance block.
// ---------------------------------------------------------------------------
package dfr_pkg;

  localparam int COS_FRAC_BITS_DEF = 14;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int WORK_BITS = 30;            // Q30 working format
  localparam int IDX_W     = 16;
  localparam int CI_W      = WORK_BITS + 1; // cosine up to 1.0
  localparam int ROOT_W    = WORK_BITS + 1; // square root result
  localparam int RAD_W     = 2 * ROOT_W;    // radicand, Q60
  localparam int SINT_W    = WORK_BITS;     // transmitted sine, below 1.0
  localparam int PROD_W    = IDX_W + CI_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int RATIO_FRAC = 31;
  localparam int Q_W       = RATIO_FRAC + 1;
  localparam int SQ_W      = 2 * Q_W;
  localparam int REFL_W    = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RAD_W-1:0] ONE60 = RAD_W'(1) << (2 * WORK_BITS);

  typedef struct packed {
    logic signed [15:0] cos_incident;
    logic [15:0]        index_incident;
    logic [15:0]        index_transmit;
  } dfr_item_t;

  typedef struct packed {
    logic [REFL_W-1:0] reflectance;
    logic              total_reflection;
  } dfr_result_t;

  // classified work item: indices after swap, cosine in Q30
  typedef struct packed {
    logic [IDX_W-1:0] ni;
    logic [IDX_W-1:0] nt;
    logic [CI_W-1:0]  ci;
  } dfr_work_t;

  // context carried down the back pipeline
  typedef struct packed {
    logic [IDX_W-1:0] ni;
    logic [IDX_W-1:0] nt;
    logic [CI_W-1:0]  ci;
    logic             tir;
    logic             den_zero;
  } dfr_ctx_t;

endpackage

// ===== design/dielectric_fresnel_reflectance_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dielectric_fresnel_reflectance_top: unpolarized Fresnel reflectance
// Exact fixed-point reflectance of a smooth dielectric boundary per item.
// ---------------------------------------------------------------------------
// Throughput is one transaction per clock when results are not stalled; an
// accepted item passes through the input queue, then a fully pipelined
// back end whose depth is set by two 31-stage square roots (incident sine and
// transmitted cosine), a 30-stage divider for the transmitted sine and
// two parallel 32-stage dividers for the amplitude ratios, plus the multiply
// and rounding stages. A stalled result holds the whole back pipeline; the
// two-entry queue keeps accepting until it is full while the back end is stopped.
// ---------------------------------------------------------------------------
module dielectric_fresnel_reflectance_top #(
  parameter int COS_FRAC_BITS = dfr_pkg::COS_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = dfr_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  dfr_pkg::dfr_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output dfr_pkg::dfr_result_t result
);

  localparam logic [63:0] FULL = 64'd1 << OUT_FRAC_BITS;

  logic               fw_valid, fw_ready;
  dfr_pkg::dfr_work_t fw_data;
  logic               qb_valid, qb_ready;
  dfr_pkg::dfr_work_t qb_data;

  // front: saturate, swap on negative cosine, scale to Q30
  dfr_front #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_front (
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .work_valid(fw_valid), .work_ready(fw_ready), .work(fw_data)
  );

  // decoupling queue between classification and arithmetic
  dfr_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fw_valid), .push_ready(fw_ready), .push_data(fw_data),
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(qb_data)
  );

  // back: sines, cosines, ratios, rounded mean
  dfr_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .work_valid(qb_valid), .work_ready(qb_ready), .work(qb_data),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.total_reflection) |->
      (result.reflectance == FULL[dfr_pkg::REFL_W-1:0]))
    else $error("total reflection without full reflectance");
  a_refl_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (64'(result.reflectance) <= FULL) || (OUT_FRAC_BITS > 16))
    else $error("reflectance above 1.0");
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// ===== design/dfr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_front: accept and classify
// Saturates the cosine, swaps indices for rays from inside, scales to Q30.
// ---------------------------------------------------------------------------
module dfr_front #(
  parameter int COS_FRAC_BITS = dfr_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                item_valid,
  output logic                item_ready,
  input  dfr_pkg::dfr_item_t  item,
  output logic                work_valid,
  input  logic                work_ready,
  output dfr_pkg::dfr_work_t  work
);

  localparam logic signed [31:0] LIM = 32'sd1 <<< COS_FRAC_BITS;

  logic signed [31:0] c_ext;
  logic signed [31:0] c_sat;
  logic signed [31:0] c_mag;
  logic               neg;

  assign item_ready = work_ready;
  assign work_valid = item_valid;

  always_comb begin
    c_ext = 32'(item.cos_incident);
    if (c_ext > LIM) begin
      c_sat = LIM;
    end else if (c_ext < -LIM) begin
      c_sat = -LIM;
    end else begin
      c_sat = c_ext;
    end
    neg   = c_sat[31];
    c_mag = neg ? -c_sat : c_sat;
    work.ni = neg ? item.index_transmit : item.index_incident;
    work.nt = neg ? item.index_incident : item.index_transmit;
    work.ci = dfr_pkg::CI_W'(c_mag) << (dfr_pkg::WORK_BITS - COS_FRAC_BITS);
  end

endmodule

// ===== design/dfr_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_queue: decoupling queue
// Short FIFO between the front and the back pipeline.
// ---------------------------------------------------------------------------
module dfr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  dfr_pkg::dfr_work_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output dfr_pkg::dfr_work_t pop_data
);

  localparam int DEPTH = dfr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  dfr_pkg::dfr_work_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count lost a push");

endmodule

// ===== design/dfr_isqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_isqrt: pipelined integer square root
// Floor square root, one root bit per stage, side data travels alongside.
// ---------------------------------------------------------------------------
module dfr_isqrt #(
  parameter int RB     = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RB-1:0]     root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int VW = 2 * RB;

  logic [VW-1:0]     v  [RB];
  logic [VW-1:0]     r  [RB+1];
  logic [SIDE_W-1:0] sd [RB+1];
  logic              vl [RB+1];

  assign v[0]  = radicand;
  assign r[0]  = '0;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar s = 0; s < RB; s++) begin : g_stage
    localparam logic [VW-1:0] B = VW'(1) << (2 * (RB - 1 - s));
    logic [VW:0] t;
    logic        take;
    assign t    = {1'b0, r[s]} + {1'b0, B};
    assign take = ({1'b0, v[s]} >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= take ? (r[s] >> 1) + B : (r[s] >> 1);
        sd[s+1] <= sd[s];
      end
    end

    if (s < RB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          v[s+1] <= take ? v[s] - t[VW-1:0] : v[s];
        end
      end
    end
  end

  assign out_valid = vl[RB];
  assign root      = r[RB][RB-1:0];
  assign out_side  = sd[RB];

endmodule

// ===== design/dfr_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_div: pipelined restoring divider
// Floor quotient of QB bits, one bit per stage; quotient must fit QB bits.
// ---------------------------------------------------------------------------
module dfr_div #(
  parameter int DW     = 47,
  parameter int VW     = 16,
  parameter int QB     = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     dividend,
  input  logic [VW-1:0]     divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QB-1:0]     quotient,
  output logic [SIDE_W-1:0] out_side
);

  localparam int W = (DW > VW + QB) ? DW : VW + QB;

  logic [W-1:0]      rem [QB];
  logic [VW-1:0]     dv  [QB];
  logic [QB-1:0]     q   [QB+1];
  logic [SIDE_W-1:0] sd  [QB+1];
  logic              vl  [QB+1];

  assign rem[0] = W'(dividend);
  assign dv[0]  = divisor;
  assign q[0]   = '0;
  assign sd[0]  = in_side;
  assign vl[0]  = in_valid;

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int I = QB - 1 - s;
    logic [W-1:0] sh;
    logic         take;
    assign sh   = W'(dv[s]) << I;
    assign take = (rem[s] >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]  <= take ? (q[s] | (QB'(1) << I)) : q[s];
        sd[s+1] <= sd[s];
      end
    end

    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= take ? rem[s] - sh : rem[s];
          dv[s+1]  <= dv[s];
        end
      end
    end
  end

  assign out_valid = vl[QB];
  assign quotient  = q[QB];
  assign out_side  = sd[QB];

endmodule

// ===== design/dfr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_back: reflectance pipeline
// Sines, transmitted cosine, amplitude ratios and the rounded mean.
// ---------------------------------------------------------------------------
module dfr_back #(
  parameter int OUT_FRAC_BITS = dfr_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 work_valid,
  output logic                 work_ready,
  input  dfr_pkg::dfr_work_t   work,
  output logic                 result_valid,
  input  logic                 result_ready,
  output dfr_pkg::dfr_result_t result
);

  localparam int CTX_W = $bits(dfr_pkg::dfr_ctx_t);
  localparam logic [63:0] RND      = 64'd1 << (62 - OUT_FRAC_BITS);
  localparam logic [63:0] TIR_FULL = 64'd1 << OUT_FRAC_BITS;
  localparam logic [dfr_pkg::Q_W-1:0] RATIO_ONE =
    dfr_pkg::Q_W'(1) << dfr_pkg::RATIO_FRAC;

  logic adv;

  // stage 1/2: incident radicand
  logic                           v1, v2;
  dfr_pkg::dfr_ctx_t              ctx1, ctx2;
  logic [dfr_pkg::RAD_W-1:0]      csq, rad1;
  // incident sine
  logic                           v3;
  logic [CTX_W-1:0]               ctx3_raw;
  dfr_pkg::dfr_ctx_t              ctx3;
  logic [dfr_pkg::ROOT_W-1:0]     sin_i;
  // stage 4: ni * sinI
  logic                           v4;
  dfr_pkg::dfr_ctx_t              ctx4, ctx4_tir;
  logic [dfr_pkg::PROD_W-1:0]     p;
  // transmitted sine
  logic                           v5;
  logic [CTX_W-1:0]               ctx5_raw;
  logic [dfr_pkg::SINT_W-1:0]     sin_t;
  // stage 6/7: transmitted radicand
  logic                           v6, v7;
  dfr_pkg::dfr_ctx_t              ctx6, ctx7;
  logic [dfr_pkg::RAD_W-1:0]      ssq, rad2;
  // transmitted cosine
  logic                           v8;
  logic [CTX_W-1:0]               ctx8_raw;
  dfr_pkg::dfr_ctx_t              ctx8;
  logic [dfr_pkg::ROOT_W-1:0]     cos_t;
  // stage 9/10: products, numerators, denominators
  logic                           v9, v10;
  dfr_pkg::dfr_ctx_t              ctx9, ctx10;
  logic [dfr_pkg::PROD_W-1:0]     a1, b1, a2, b2;
  logic [dfr_pkg::SUM_W-1:0]      na, da, nb, db;
  logic                           zb10;
  // ratios
  logic                           va, vb;
  logic [CTX_W-1:0]               ctxa_raw;
  dfr_pkg::dfr_ctx_t              ctxa;
  logic                           zb_q;
  logic [dfr_pkg::Q_W-1:0]        qa_raw, qb_raw, qa, qb;
  // stage 11: squares
  logic                           v11;
  logic                           tir11;
  logic [dfr_pkg::SQ_W-1:0]       sqa, sqb;
  logic [63:0]                    rounded;

  assign adv        = !result_valid || result_ready;
  assign work_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v4 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1 <= work_valid;
      v2 <= v1;
      v4 <= v3;
      v6 <= v5;
      v7 <= v6;
      v9 <= v8;
      v10 <= v9;
      v11 <= va && vb;
      result_valid <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1.ni       <= work.ni;
      ctx1.nt       <= work.nt;
      ctx1.ci       <= work.ci;
      ctx1.tir      <= 1'b0;
      ctx1.den_zero <= 1'b0;
      csq  <= dfr_pkg::RAD_W'(work.ci) * dfr_pkg::RAD_W'(work.ci);
      ctx2 <= ctx1;
      rad1 <= dfr_pkg::ONE60 - csq;
    end
  end

  dfr_isqrt #(.RB(dfr_pkg::ROOT_W), .SIDE_W(CTX_W)) u_sqrt_i (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2), .radicand(rad1),
    .in_side(CTX_W'(ctx2)), .out_valid(v3), .root(sin_i), .out_side(ctx3_raw)
  );
  assign ctx3 = dfr_pkg::dfr_ctx_t'(ctx3_raw);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx4 <= ctx3;
      p    <= dfr_pkg::PROD_W'(ctx3.ni) * dfr_pkg::PROD_W'(sin_i);
    end
  end

  // total internal reflection: ni * sinI >= nt * 1.0
  always_comb begin
    ctx4_tir     = ctx4;
    ctx4_tir.tir = (p >= (dfr_pkg::PROD_W'(ctx4.nt) << dfr_pkg::WORK_BITS));
  end

  dfr_div #(.DW(dfr_pkg::PROD_W), .VW(dfr_pkg::IDX_W), .QB(dfr_pkg::SINT_W),
            .SIDE_W(CTX_W)) u_div_sint (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v4), .dividend(p),
    .divisor(ctx4.nt), .in_side(CTX_W'(ctx4_tir)), .out_valid(v5),
    .quotient(sin_t), .out_side(ctx5_raw)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx6 <= dfr_pkg::dfr_ctx_t'(ctx5_raw);
      ssq  <= dfr_pkg::RAD_W'(sin_t) * dfr_pkg::RAD_W'(sin_t);
      ctx7 <= ctx6;
      rad2 <= dfr_pkg::ONE60 - ssq;
    end
  end

  dfr_isqrt #(.RB(dfr_pkg::ROOT_W), .SIDE_W(CTX_W)) u_sqrt_t (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v7), .radicand(rad2),
    .in_side(CTX_W'(ctx7)), .out_valid(v8), .root(cos_t), .out_side(ctx8_raw)
  );
  assign ctx8 = dfr_pkg::dfr_ctx_t'(ctx8_raw);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx9 <= ctx8;
      a1 <= dfr_pkg::PROD_W'(ctx8.nt) * dfr_pkg::PROD_W'(ctx8.ci);
      b1 <= dfr_pkg::PROD_W'(ctx8.ni) * dfr_pkg::PROD_W'(cos_t);
      a2 <= dfr_pkg::PROD_W'(ctx8.ni) * dfr_pkg::PROD_W'(ctx8.ci);
      b2 <= dfr_pkg::PROD_W'(ctx8.nt) * dfr_pkg::PROD_W'(cos_t);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      na <= (a1 >= b1) ? dfr_pkg::SUM_W'(a1 - b1) : dfr_pkg::SUM_W'(b1 - a1);
      da <= dfr_pkg::SUM_W'(a1) + dfr_pkg::SUM_W'(b1);
      nb <= (a2 >= b2) ? dfr_pkg::SUM_W'(a2 - b2) : dfr_pkg::SUM_W'(b2 - a2);
      db <= dfr_pkg::SUM_W'(a2) + dfr_pkg::SUM_W'(b2);
      ctx10 <= '{ni: ctx9.ni, nt: ctx9.nt, ci: ctx9.ci, tir: ctx9.tir,
                 den_zero: ((a1 == '0) && (b1 == '0))};
      zb10  <= ((a2 == '0) && (b2 == '0));
    end
  end

  dfr_div #(.DW(dfr_pkg::SUM_W + dfr_pkg::RATIO_FRAC), .VW(dfr_pkg::SUM_W),
            .QB(dfr_pkg::Q_W), .SIDE_W(CTX_W)) u_div_par (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v10),
    .dividend({na, {dfr_pkg::RATIO_FRAC{1'b0}}}), .divisor(da),
    .in_side(CTX_W'(ctx10)), .out_valid(va), .quotient(qa_raw),
    .out_side(ctxa_raw)
  );

  dfr_div #(.DW(dfr_pkg::SUM_W + dfr_pkg::RATIO_FRAC), .VW(dfr_pkg::SUM_W),
            .QB(dfr_pkg::Q_W), .SIDE_W(1)) u_div_perp (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v10),
    .dividend({nb, {dfr_pkg::RATIO_FRAC{1'b0}}}), .divisor(db),
    .in_side(zb10), .out_valid(vb), .quotient(qb_raw), .out_side(zb_q)
  );

  assign ctxa = dfr_pkg::dfr_ctx_t'(ctxa_raw);
  // zero denominator: ratio taken as its limit 1.0
  assign qa = ctxa.den_zero ? RATIO_ONE : qa_raw;
  assign qb = zb_q ? RATIO_ONE : qb_raw;

  always_ff @(posedge clk) begin
    if (adv) begin
      tir11 <= ctxa.tir;
      sqa   <= dfr_pkg::SQ_W'(qa) * dfr_pkg::SQ_W'(qa);
      sqb   <= dfr_pkg::SQ_W'(qb) * dfr_pkg::SQ_W'(qb);
    end
  end

  assign rounded = ((64'(sqa) + 64'(sqb) + RND) >> (63 - OUT_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (adv) begin
      result.total_reflection <= tir11;
      result.reflectance      <= tir11 ? TIR_FULL[dfr_pkg::REFL_W-1:0]
                                       : rounded[dfr_pkg::REFL_W-1:0];
    end
  end

endmodule

// ===== verif/tb_dielectric_fresnel_reflectance_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dielectric_fresnel_reflectance_top: self-checking bench
// Sends directed and random incidence transactions with random gaps and
// result back-pressure. Each accepted transaction is predicted in
// fixed point and checked in order against the returned reflectance.
// ---------------------------------------------------------------------------
class fresnel_scoreboard;
  dfr_pkg::dfr_result_t expected_q[$];
  int                   mismatches;

  function new();
    mismatches = 0;
  endfunction

  // floor integer square root of a 64-bit value
  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // floor(num * 2^31 / den), zero den gives 1.0
  static function longint unsigned amp_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    if (den == 0) return 64'd1 << 31;
    q   = (num >= den) ? 64'd1 : 64'd0;
    rem = num - q * den;
    for (int i = 0; i < 31; i++) begin
      rem <<= 1;
      q   <<= 1;
      if (rem >= den) begin
        rem -= den;
        q   |= 64'd1;
      end
    end
    return q;
  endfunction

  static function longint unsigned abs_gap(longint unsigned a, longint unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  static function dfr_pkg::dfr_result_t reflectance_of(dfr_pkg::dfr_item_t it);
    dfr_pkg::dfr_result_t res;
    int                   c;
    int                   lim;
    longint unsigned      ni, nt, ci, sin_i, sin_t, cos_t, qa, qb, total;
    lim = 1 << dfr_pkg::COS_FRAC_BITS_DEF;
    c   = it.cos_incident;
    ni  = it.index_incident;
    nt  = it.index_transmit;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    if (c < 0) begin
      // ray from inside: swap sides
      ci = ni; ni = nt; nt = ci;
      c  = -c;
    end
    ci    = longint'(c) << (dfr_pkg::WORK_BITS - dfr_pkg::COS_FRAC_BITS_DEF);
    sin_i = int_sqrt((64'd1 << 60) - ci * ci);
    if (ni * sin_i >= nt * (64'd1 << 30)) begin
      res.reflectance      = dfr_pkg::REFL_W'(64'd1 << dfr_pkg::OUT_FRAC_BITS_DEF);
      res.total_reflection = 1'b1;
      return res;
    end
    sin_t = (ni * sin_i) / nt;
    cos_t = int_sqrt((64'd1 << 60) - sin_t * sin_t);
    qa    = amp_ratio(abs_gap(nt * ci, ni * cos_t), nt * ci + ni * cos_t);
    qb    = amp_ratio(abs_gap(ni * ci, nt * cos_t), ni * ci + nt * cos_t);
    total = qa * qa + qb * qb;
    res.reflectance = dfr_pkg::REFL_W'((total + (64'd1 << (62 - dfr_pkg::OUT_FRAC_BITS_DEF)))
                                       >> (63 - dfr_pkg::OUT_FRAC_BITS_DEF));
    res.total_reflection = 1'b0;
    return res;
  endfunction

  function void note_item(dfr_pkg::dfr_item_t it);
    expected_q.push_back(reflectance_of(it));
  endfunction

  function void check_result(dfr_pkg::dfr_result_t got);
    dfr_pkg::dfr_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result refl=%0d tir=%0b", $realtime,
               got.reflectance, got.total_reflection);
      mismatches++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.reflectance !== exp_r.reflectance) begin
      $display("%0t: reflectance expected %0d actual %0d", $realtime,
               exp_r.reflectance, got.reflectance);
      mismatches++;
    end
    if (got.total_reflection !== exp_r.total_reflection) begin
      $display("%0t: total_reflection expected %0b actual %0b", $realtime,
               exp_r.total_reflection, got.total_reflection);
      mismatches++;
    end
  endfunction
endclass

module tb_dielectric_fresnel_reflectance_top;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  dfr_pkg::dfr_item_t   item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  dfr_pkg::dfr_result_t result;

  fresnel_scoreboard sb = new();
  bit                burst_in  = 0;  // gap-free stretches on the input side
  bit                burst_out = 0;  // stall-free stretches on the output side

  always #5 clk = ~clk;

  dielectric_fresnel_reflectance_top dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // Send one transaction: optional idle gap, then hold valid until accepted.
  task automatic send_item(dfr_pkg::dfr_item_t it);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  task automatic send_fields(int c, int ni, int nt);
    dfr_pkg::dfr_item_t it;
    it.cos_incident   = 16'(c);
    it.index_incident = 16'(ni);
    it.index_transmit = 16'(nt);
    send_item(it);
  endtask

  // Random index: half physical (1.0 .. 3.0 in Q4.12), else up to 1.0 or anything.
  function automatic int rand_index();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 65535);
      1:       return $urandom_range(1, 4096);
      default: return $urandom_range(4096, 12288);
    endcase
  endfunction

  function automatic int rand_cos();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 65535);           // full span, saturates
      1:       return $urandom_range(0, 400);             // near grazing
      2:       return 16'(-$urandom_range(0, 16384));     // from inside
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  // Result side: random stall before each result, then take it.
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  initial begin : stimulus
    int drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cosine extremes and saturation, index extremes, special cases.
    send_fields(16384, 4096, 6144);     // normal incidence
    send_fields(32767, 4096, 6144);     // cosine beyond one
    send_fields(-32768, 4096, 6144);    // cosine below minus one, swapped
    send_fields(-16384, 6144, 4096);
    send_fields(0, 4096, 6144);         // grazing
    send_fields(0, 6144, 4096);         // grazing, denser side
    send_fields(4000, 6144, 4096);      // total internal reflection
    send_fields(-4000, 4096, 6144);     // total internal reflection via swap
    send_fields(8192, 4096, 4096);      // matched indices
    send_fields(8192, 1, 65535);
    send_fields(8192, 65535, 1);
    send_fields(16384, 65535, 65535);
    send_fields(16384, 1, 1);
    send_fields(16384, 4096, 0);        // zero transmitted index
    send_fields(-8192, 0, 4096);        // zero transmitted index after swap
    send_fields(0, 0, 4096);            // zero incident index at grazing
    send_fields(-32768, 4096, 0);       // zero incident index after swap
    send_fields(1, 65535, 65535);
    send_fields(16383, 4096, 5000);
    send_fields(16'h5555, 16'hAAAA, 16'h5555);
    send_fields(16'hAAAA, 16'h5555, 16'hAAAA);

    for (int n = 0; n < 1400; n++) begin
      if (n % 100 == 0) begin
        burst_in  = ($urandom_range(0, 3) == 0);
        burst_out = ($urandom_range(0, 3) == 0);
      end
      send_fields(rand_cos(), rand_index(), rand_index());
    end
    item_valid <= 1'b0;
    burst_out = 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    // Wait longer so that any stray result can show up.
    drain = 400;
    repeat (drain) @(posedge clk);

    if (sb.mismatches == 0)
      $display("tb_dielectric_fresnel_reflectance_top passed");
    else
      $display("tb_dielectric_fresnel_reflectance_top failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_dielectric_fresnel_reflectance_top failed");
    $finish;
  end

endmodule

// ===== dielectric_fresnel_reflectance_top.f =====
design/dfr_pkg.sv
design/dfr_front.sv
design/dfr_queue.sv
design/dfr_isqrt.sv
design/dfr_div.sv
design/dfr_back.sv
design/dielectric_fresnel_reflectance_top.sv
verif/tb_dielectric_fresnel_reflectance_top.sv
